// File: sv/text_console_writer_unit_defines.svh
// Assertion macros shared by the text console writer RTL.
// Included by the files that assert; depends on nothing else.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("text console writer check failed");
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("text console writer check failed");
`else
`define TCW_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/tcw_pkg.sv
// Types, command codes and constants of the text console writer.
// Used by the controller, datapath and top level; depends on nothing.
`default_nettype none
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int ROW_FW = 5;
	localparam int COL_FW = 7;
	localparam int POS_FW = 11;
	localparam int IDX_FW = 11;

	localparam logic [1:0] CMD_PUT  = 2'd0;
	localparam logic [1:0] CMD_FILL = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [7:0]        char_code;
		logic [3:0]        fg_color;
		logic [3:0]        bg_color;
		logic              move_cursor;
		logic [IDX_FW-1:0] cell_index;
	} tcw_in_t;

	typedef struct packed {
		logic [15:0]       cell_value;
		logic [ROW_FW-1:0] cursor_row;
		logic [COL_FW-1:0] cursor_col;
		logic [POS_FW-1:0] cursor_pos;
		logic              cursor_valid;
		logic [3:0]        screen_bg;
	} tcw_out_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic put;
		logic line;
		logic scroll;
		logic capture;
	} tcw_ctl_t;

	typedef struct packed {
		logic [1:0] req_cmd;
		logic       req_newline;
		logic       sweep_last;
		logic       col_last;
		logic       row_last;
		logic       scroll_last;
	} tcw_sts_t;

	function automatic logic [15:0] blank_cell(input logic [3:0] bg);
		blank_cell = {bg, 4'h0, CH_SPACE};
	endfunction

endpackage
`default_nettype wire

// File: sv/tcw_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg for the command codes and the control and status structs.
`default_nettype none
module tcw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire tcw_pkg::tcw_sts_t sts,
	output      logic              busy,
	output      tcw_pkg::tcw_ctl_t ctl
);
	import tcw_pkg::*;

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_PUT    = 3'd2;
	localparam logic [2:0] S_LINE   = 3'd3;
	localparam logic [2:0] S_SCROLL = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_FILL   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       wrap_bottom;

	assign wrap_bottom = sts.col_last && sts.row_last;
	assign busy        = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_INIT: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (sts.req_cmd)
						CMD_PUT:  state_d = sts.req_newline ? S_LINE : S_PUT;
						CMD_FILL: state_d = S_FILL;
						default:  state_d = S_READ;
					endcase
				end
			end
			S_PUT: begin
				ctl.put = 1'b1;
				if (wrap_bottom) begin
					state_d = S_SCROLL;
				end else begin
					ctl.capture = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_LINE: begin
				ctl.line = 1'b1;
				if (sts.col_last) begin
					if (sts.row_last) begin
						state_d = S_SCROLL;
					end else begin
						ctl.capture = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			S_SCROLL: begin
				ctl.scroll = 1'b1;
				if (sts.scroll_last) begin
					ctl.capture = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_READ: begin
				ctl.capture = 1'b1;
				state_d     = S_IDLE;
			end
			S_FILL: begin
				ctl.sweep = 1'b1;
				if (sts.sweep_last) begin
					ctl.capture = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/tcw_datapath.sv
// Datapath of the text console writer: screen store, cursor, sweep counters, result.
// Depends on tcw_pkg and tcw_ram.
`default_nettype none
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcw_pkg::tcw_in_t  request,
	input  wire tcw_pkg::tcw_ctl_t ctl,
	output      tcw_pkg::tcw_sts_t sts,
	output      logic              done,
	output      tcw_pkg::tcw_out_t result
);
	import tcw_pkg::*;

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int COL_W  = $clog2(COLUMNS);

	tcw_in_t           item_q;
	logic              range_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CNT_W-1:0]  pos_q;
	logic [3:0]        bg_q;
	logic [CNT_W-1:0]  sweep_q;
	logic [CNT_W-1:0]  src_q;
	logic [CNT_W-1:0]  dst_q;
	logic              copy_s1;
	logic [15:0]       value_q;
	logic              valid_q;
	logic              done_q;

	logic              src_done;
	logic              scroll_we;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic [ADDR_W-1:0] raddr;
	logic [15:0]       rdata;
	logic [IDX_FW+ADDR_W-1:0] idx_ext;
	logic [ROW_W+ROW_FW-1:0]  row_ext;
	logic [COL_W+COL_FW-1:0]  col_ext;
	logic [CNT_W+POS_FW-1:0]  pos_ext;

	assign src_done  = (src_q == CNT_W'(CELLS));
	assign scroll_we = copy_s1 || src_done;

	assign sts.req_cmd     = request.cmd;
	assign sts.req_newline = (request.char_code == CH_NEWLINE);
	assign sts.sweep_last  = (sweep_q == CNT_W'(CELLS - 1));
	assign sts.col_last    = (col_q == COL_W'(COLUMNS - 1));
	assign sts.row_last    = (row_q == ROW_W'(ROWS - 1));
	assign sts.scroll_last = scroll_we && (dst_q == CNT_W'(CELLS - 1));

	assign idx_ext = {{ADDR_W{1'b0}}, request.cell_index};
	assign raddr   = ctl.scroll ? src_q[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[ADDR_W-1:0];
		wdata = blank_cell(bg_q);
		if (ctl.sweep) begin
			we    = 1'b1;
			waddr = sweep_q[ADDR_W-1:0];
		end else if (ctl.put) begin
			we    = 1'b1;
			wdata = {item_q.bg_color, item_q.fg_color, item_q.char_code};
		end else if (ctl.line) begin
			we = 1'b1;
		end else if (ctl.scroll) begin
			we    = scroll_we;
			waddr = dst_q[ADDR_W-1:0];
			if (copy_s1) begin
				wdata = rdata;
			end
		end
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q  <= request;
			range_q <= (32'(request.cell_index) < CELLS);
		end
		if (ctl.load) begin
			src_q   <= CNT_W'(COLUMNS);
			dst_q   <= '0;
			copy_s1 <= 1'b0;
		end else if (ctl.scroll) begin
			copy_s1 <= !src_done;
			if (!src_done) begin
				src_q <= src_q + 1'b1;
			end
			if (scroll_we) begin
				dst_q <= dst_q + 1'b1;
			end
		end
		if (ctl.capture) begin
			value_q <= (item_q.cmd == CMD_READ && range_q) ? rdata : 16'h0000;
			valid_q <= (item_q.cmd == CMD_PUT) ? item_q.move_cursor : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			pos_q   <= '0;
			bg_q    <= '0;
			sweep_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.capture;
			if (ctl.load && request.cmd == CMD_FILL) begin
				row_q   <= '0;
				col_q   <= '0;
				pos_q   <= '0;
				bg_q    <= request.bg_color;
				sweep_q <= '0;
			end else if (ctl.sweep) begin
				sweep_q <= sweep_q + 1'b1;
			end else if (ctl.put || ctl.line) begin
				pos_q <= pos_q + 1'b1;
				if (sts.col_last) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (ctl.scroll && sts.scroll_last) begin
				row_q <= ROW_W'(ROWS - 1);
				pos_q <= CNT_W'(CELLS - COLUMNS);
			end
		end
	end

	assign row_ext = {{ROW_FW{1'b0}}, row_q};
	assign col_ext = {{COL_FW{1'b0}}, col_q};
	assign pos_ext = {{POS_FW{1'b0}}, pos_q};

	assign done                = done_q;
	assign result.cell_value   = value_q;
	assign result.cursor_row   = row_ext[ROW_FW-1:0];
	assign result.cursor_col   = col_ext[COL_FW-1:0];
	assign result.cursor_pos   = pos_ext[POS_FW-1:0];
	assign result.cursor_valid = valid_q;
	assign result.screen_bg    = bg_q;

endmodule
`default_nettype wire

// File: sv/text_console_writer_unit.sv
// Top level of the text console writer: controller plus datapath.
// Depends on tcw_pkg, tcw_ctrl, tcw_datapath and the assertion macro header.
//
//   Port group      Handshake            Payload
//   command item    start / busy         request (tcw_in_t)
//   result item     done (one cycle)     result (tcw_out_t)
//
// A put of an ordinary character passes through the put state; a read and the
// unused command pass through the read state. A newline blanks the cells from
// the cursor to the end of its row, one store write per blanked cell. A wrap past
// the last cell adds a scroll, which moves every row up and blanks the last; a
// fill blanks every cell. After reset the block clears the store with busy high.
// The result holds until the next command; the receiver cannot stall it.
`default_nettype none
`include "text_console_writer_unit_defines.svh"
module text_console_writer_unit #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	input  wire tcw_pkg::tcw_in_t request,
	output      logic             done,
	output      tcw_pkg::tcw_out_t result
);
	import tcw_pkg::*;

	tcw_ctl_t ctl;
	tcw_sts_t sts;

	tcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.busy  (busy),
		.ctl   (ctl)
	);

	tcw_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

	`TCW_ASSERT_IMPL(a_done_when_idle, clk, arst_n, done, !busy)
	`TCW_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, start && !busy, busy)
	`TCW_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

endmodule
`default_nettype wire
